/* hw/rtl/mbda_pkg.sv */
// Shared types, constants and helpers of the multi-bin DFT accumulator.
package mbda_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int CORDIC_LAT    = CORDIC_STAGES + 2;
   localparam int ELEM_W        = 10;
   localparam int SAMPLE_W      = 16;
   localparam int TIME_W        = 32;
   localparam int FREQ_W        = 32;
   localparam int ACC_W         = 48;
   localparam int OUT_W         = 64;
   localparam int MAX_LANES     = 4;
   localparam int QUEUE_DEPTH   = 4;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_A       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_B       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_C       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_D       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQS_IN_USE = 3'd4;

   localparam logic CMD_ACCUM = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // arctangent of 2^-i in 2^-32 turns
   localparam logic [31:0] ATAN_TURNS [CORDIC_STAGES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861
   };

   localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

   typedef struct packed {
      logic [MAX_LANES-1:0][FREQ_W-1:0] freq;
      logic [2:0]                       freqs_in_use;
   } cfg_type;

   typedef struct packed {
      logic                       cmd;
      logic                       elem_ok;
      logic [ELEM_W-1:0]          element;
      logic                       bin_ok;
      logic [1:0]                 bin;
      logic [MAX_LANES-1:0]       lane_en;
      logic [TIME_W-1:0]          step_time;
      logic signed [SAMPLE_W-1:0] sample;
      logic [TIME_W-1:0]          interval;
   } item_type;

   // round half up to Q1.15 and clamp to +-32767
   function automatic logic signed [15:0] to_q15(input logic signed [32:0] v);
      logic signed [33:0] r;
      r = ($signed({v[32], v}) + 34'sd16384) >>> 15;
      if (r > 34'sd32767) begin
         to_q15 = 16'sd32767;
      end else if (r < -34'sd32767) begin
         to_q15 = -16'sd32767;
      end else begin
         to_q15 = r[15:0];
      end
   endfunction

endpackage

/* hw/rtl/mbda_front.sv */
// Front end: CSRs, step interval tracking and request classification.
module mbda_front import mbda_pkg::*; #(
   parameter int NUM_BINS     = 4,
   parameter int NUM_ELEMENTS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wen,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic [ELEM_W-1:0]          req_element,
   input  logic [1:0]                 req_bin,
   input  logic [TIME_W-1:0]          req_step_time,
   input  logic                       req_first_of_step,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       q_not_full,
   input  logic                       clear_busy,
   output logic                       push,
   output item_type                   push_item,
   output cfg_type                    cfg
);

   localparam int NB = (NUM_BINS < MAX_LANES) ? NUM_BINS : MAX_LANES;

   logic [FREQ_W-1:0] freq_ff [MAX_LANES];
   logic [2:0]        use_ff;
   logic [TIME_W-1:0] prev_time_ff, prev_time_in;
   logic [TIME_W-1:0] interval_ff, interval_in;
   logic [2:0]        use_eff;

   assign req_ready = q_not_full & ~clear_busy;
   assign push      = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_LANES; i++) begin
            freq_ff[i] <= '0;
         end
         use_ff <= 3'd4;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_FREQ_A:       freq_ff[0] <= csr_wdata;
            CSR_FREQ_B:       freq_ff[1] <= csr_wdata;
            CSR_FREQ_C:       freq_ff[2] <= csr_wdata;
            CSR_FREQ_D:       freq_ff[3] <= csr_wdata;
            CSR_FREQS_IN_USE: use_ff <= csr_wdata[2:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_LANES; i++) begin
         cfg.freq[i] = freq_ff[i];
      end
      cfg.freqs_in_use = use_ff;
   end

   always_comb begin
      prev_time_in = prev_time_ff;
      interval_in  = interval_ff;
      if (push && req_cmd == CMD_ACCUM && req_first_of_step) begin
         interval_in  = req_step_time - prev_time_ff;
         prev_time_in = req_step_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
         interval_ff  <= '0;
      end else begin
         prev_time_ff <= prev_time_in;
         interval_ff  <= interval_in;
      end
   end

   always_comb begin
      if (use_ff == 3'd0) begin
         use_eff = 3'd1;
      end else if (use_ff > 3'(NB)) begin
         use_eff = 3'(NB);
      end else begin
         use_eff = use_ff;
      end
      push_item.cmd       = req_cmd;
      push_item.elem_ok   = {7'b0, req_element} < 17'(NUM_ELEMENTS);
      push_item.element   = req_element;
      push_item.bin_ok    = {1'b0, req_bin} < 3'(NB);
      push_item.bin       = req_bin;
      for (int b = 0; b < MAX_LANES; b++) begin
         push_item.lane_en[b] = 3'(b) < use_eff;
      end
      push_item.step_time = req_step_time;
      push_item.sample    = req_sample;
      // reads carry the interval in force at their place in the stream
      push_item.interval  = interval_ff;
   end

endmodule

/* hw/rtl/mbda_queue.sv */
// Small request queue between front and back end.
module mbda_queue import mbda_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type pop_item,
   output logic     not_empty,
   output logic     not_full
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   item_type        entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]     count_ff, count_in;

   assign not_empty = count_ff != '0;
   assign not_full  = count_ff != (PW+1)'(QUEUE_DEPTH);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

/* hw/rtl/mbda_cordic.sv */
// Pipelined CORDIC phasor generator: phase in turns to Q1.15 cos and sin.
module mbda_cordic import mbda_pkg::*; #(
   parameter int TABLE_BITS = 10
) (
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        phase,
   output logic signed [15:0] cs,
   output logic signed [15:0] sn
);

   logic signed [32:0] x_ff [CORDIC_STAGES+1];
   logic signed [32:0] y_ff [CORDIC_STAGES+1];
   logic signed [31:0] z_ff [CORDIC_STAGES+1];
   logic [1:0]         quad_ff [CORDIC_STAGES+1];
   logic [31:0]        p, u;
   logic signed [15:0] c0, s0;

   // keep only the top TABLE_BITS of phase, rotate by an eighth turn for the quadrant
   assign p = phase & ~(32'hFFFF_FFFF >> TABLE_BITS);
   assign u = p + 32'h2000_0000;

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= CORDIC_X0;
         y_ff[0]    <= '0;
         z_ff[0]    <= $signed({2'b00, u[29:0]}) - 32'sh2000_0000;
         quad_ff[0] <= u[31:30];
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      logic signed [32:0] dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][31]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - $signed(ATAN_TURNS[i]);
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + $signed(ATAN_TURNS[i]);
            end
            quad_ff[i+1] <= quad_ff[i];
         end
      end
   end

   assign c0 = to_q15(x_ff[CORDIC_STAGES]);
   assign s0 = to_q15(y_ff[CORDIC_STAGES]);

   always_ff @(posedge clock) begin
      if (en) begin
         case (quad_ff[CORDIC_STAGES])
            2'd0: begin
               cs <= c0;
               sn <= s0;
            end
            2'd1: begin
               cs <= -s0;
               sn <= c0;
            end
            2'd2: begin
               cs <= -c0;
               sn <= -s0;
            end
            default: begin
               cs <= s0;
               sn <= -c0;
            end
         endcase
      end
   end

endmodule

/* hw/rtl/mbda_back.sv */
// Back end: phase multiply, phasors, accumulator memories and scaled read-out.
module mbda_back import mbda_pkg::*; #(
   parameter int NUM_BINS     = 4,
   parameter int NUM_ELEMENTS = 1024,
   parameter int TABLE_BITS   = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  item_type                q_item,
   input  logic                    q_not_empty,
   output logic                    q_pop,
   output logic                    clear_busy,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_real_part,
   output logic signed [OUT_W-1:0] rsp_imag_part
);

   localparam int NB        = (NUM_BINS < MAX_LANES) ? NUM_BINS : MAX_LANES;
   localparam int MEM_DEPTH = (NUM_ELEMENTS < (1 << ELEM_W)) ? NUM_ELEMENTS : (1 << ELEM_W);
   localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int MEM_WORDS = 1 << AW;

   logic en;

   // stage A: phase = freq * time
   logic              a_valid_ff;
   item_type          a_item_ff;
   logic [31:0]       phase_ff [NB];

   // phasor latency line
   logic              c_valid_ff [CORDIC_LAT];
   item_type          c_item_ff  [CORDIC_LAT];
   logic signed [15:0] cs [NB];
   logic signed [15:0] sn [NB];

   // stage E: products
   logic              e_valid_ff;
   item_type          e_item_ff;
   logic signed [31:0] prod_re_ff [NB];
   logic signed [31:0] prod_im_ff [NB];

   // stage M: rounded terms, memory read data, update
   logic              m_valid_ff;
   item_type          m_item_ff;
   logic signed [16:0] tr_ff [NB];
   logic signed [16:0] ti_ff [NB];
   logic [2*ACC_W-1:0] rdata_ff [NB];
   logic [ACC_W-1:0]   base_re [NB];
   logic [ACC_W-1:0]   base_im [NB];
   logic [ACC_W-1:0]   sum_re [NB];
   logic [ACC_W-1:0]   sum_im [NB];
   logic [NB-1:0]      we;
   logic [NB-1:0]      lw_valid_ff;
   logic [AW-1:0]      lw_addr_ff;
   logic [2*ACC_W-1:0] lw_data_ff [NB];
   logic [AW-1:0]      m_addr;
   logic [ACC_W-1:0]   sel_re, sel_im;

   // clearing pass
   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;

   // stage D: magnitudes
   logic              d_valid_ff;
   logic              d_neg_re_ff, d_neg_im_ff;
   logic [ACC_W-1:0]  d_mag_re_ff, d_mag_im_ff;
   logic [32:0]       d_mult_ff;

   // stage P: partial products
   logic              p_valid_ff;
   logic              p_neg_re_ff, p_neg_im_ff;
   logic [64:0]       p_lo_re_ff, p_lo_im_ff;
   logic [48:0]       p_hi_re_ff, p_hi_im_ff;

   // stage Q: full product
   logic              q_valid_ff;
   logic              q_neg_re_ff, q_neg_im_ff;
   logic [80:0]       q_prod_re_ff, q_prod_im_ff;

   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_real_ff, rsp_imag_ff;

   assign en         = ~rsp_valid_ff | rsp_ready;
   assign q_pop      = en & q_not_empty & ~clr_busy_ff;
   assign clear_busy = clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
         for (int i = 0; i < CORDIC_LAT; i++) begin
            c_valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         a_valid_ff    <= q_pop;
         c_valid_ff[0] <= a_valid_ff;
         for (int i = 1; i < CORDIC_LAT; i++) begin
            c_valid_ff[i] <= c_valid_ff[i-1];
         end
         e_valid_ff <= c_valid_ff[CORDIC_LAT-1];
         m_valid_ff <= e_valid_ff;
         d_valid_ff <= m_valid_ff & (m_item_ff.cmd == CMD_READ);
         p_valid_ff <= d_valid_ff;
         q_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_item_ff    <= q_item;
         c_item_ff[0] <= a_item_ff;
         for (int i = 1; i < CORDIC_LAT; i++) begin
            c_item_ff[i] <= c_item_ff[i-1];
         end
         e_item_ff <= c_item_ff[CORDIC_LAT-1];
         m_item_ff <= e_item_ff;
      end
   end

   assign m_addr = m_item_ff.element[AW-1:0];

   for (genvar b = 0; b < NB; b++) begin : g_lane
      logic [2*ACC_W-1:0] mem [MEM_WORDS];
      logic               mem_we;
      logic [AW-1:0]      mem_waddr;
      logic [2*ACC_W-1:0] mem_wdata;
      logic               fwd;

      always_ff @(posedge clock) begin
         if (en) begin
            phase_ff[b] <= cfg.freq[b] * q_item.step_time;
         end
      end

      mbda_cordic #(.TABLE_BITS(TABLE_BITS)) u_cordic (
         .clock (clock),
         .en    (en),
         .phase (phase_ff[b]),
         .cs    (cs[b]),
         .sn    (sn[b])
      );

      always_ff @(posedge clock) begin
         if (en) begin
            prod_re_ff[b] <= c_item_ff[CORDIC_LAT-1].sample * cs[b];
            prod_im_ff[b] <= c_item_ff[CORDIC_LAT-1].sample * (16'sd0 - sn[b]);
            tr_ff[b]      <= 17'((prod_re_ff[b] + 32'sd16384) >>> 15);
            ti_ff[b]      <= 17'((prod_im_ff[b] + 32'sd16384) >>> 15);
         end
      end

      // the previous update lands in memory at the edge this read is taken
      assign fwd        = lw_valid_ff[b] && (lw_addr_ff == m_addr);
      assign base_re[b] = fwd ? lw_data_ff[b][2*ACC_W-1:ACC_W] : rdata_ff[b][2*ACC_W-1:ACC_W];
      assign base_im[b] = fwd ? lw_data_ff[b][ACC_W-1:0] : rdata_ff[b][ACC_W-1:0];
      assign sum_re[b]  = base_re[b] + {{(ACC_W-17){tr_ff[b][16]}}, tr_ff[b]};
      assign sum_im[b]  = base_im[b] + {{(ACC_W-17){ti_ff[b][16]}}, ti_ff[b]};
      assign we[b]      = en && m_valid_ff && (m_item_ff.cmd == CMD_ACCUM)
                          && m_item_ff.elem_ok && m_item_ff.lane_en[b];

      assign mem_we    = clr_busy_ff | we[b];
      assign mem_waddr = clr_busy_ff ? clr_addr_ff : m_addr;
      assign mem_wdata = clr_busy_ff ? '0 : {sum_re[b], sum_im[b]};

      always_ff @(posedge clock) begin
         if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
         end
         if (en) begin
            rdata_ff[b] <= mem[e_item_ff.element[AW-1:0]];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            lw_data_ff[b] <= {sum_re[b], sum_im[b]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= '0;
      end else if (en) begin
         lw_valid_ff <= we;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lw_addr_ff <= m_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(MEM_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sel_re = '0;
      sel_im = '0;
      if (m_item_ff.elem_ok && m_item_ff.bin_ok) begin
         for (int b = 0; b < NB; b++) begin
            if (m_item_ff.bin == 2'(b)) begin
               sel_re = base_re[b];
               sel_im = base_im[b];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_neg_re_ff  <= sel_re[ACC_W-1];
         d_neg_im_ff  <= sel_im[ACC_W-1];
         d_mag_re_ff  <= sel_re[ACC_W-1] ? (ACC_W'(0) - sel_re) : sel_re;
         d_mag_im_ff  <= sel_im[ACC_W-1] ? (ACC_W'(0) - sel_im) : sel_im;
         d_mult_ff    <= {m_item_ff.interval, 1'b0};

         p_neg_re_ff  <= d_neg_re_ff;
         p_neg_im_ff  <= d_neg_im_ff;
         p_lo_re_ff   <= {33'b0, d_mag_re_ff[31:0]} * {32'b0, d_mult_ff};
         p_lo_im_ff   <= {33'b0, d_mag_im_ff[31:0]} * {32'b0, d_mult_ff};
         p_hi_re_ff   <= {33'b0, d_mag_re_ff[ACC_W-1:32]} * {16'b0, d_mult_ff};
         p_hi_im_ff   <= {33'b0, d_mag_im_ff[ACC_W-1:32]} * {16'b0, d_mult_ff};

         q_neg_re_ff  <= p_neg_re_ff;
         q_neg_im_ff  <= p_neg_im_ff;
         q_prod_re_ff <= {16'b0, p_lo_re_ff} + {p_hi_re_ff, 32'b0};
         q_prod_im_ff <= {16'b0, p_lo_im_ff} + {p_hi_im_ff, 32'b0};
      end
   end

   function automatic logic [OUT_W-1:0] sat_sign(input logic neg, input logic [80:0] prod);
      logic [OUT_W-1:0] lim, mag;
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      mag = (prod > {17'b0, lim}) ? lim : prod[OUT_W-1:0];
      sat_sign = neg ? (OUT_W'(0) - mag) : mag;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= q_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_real_ff <= sat_sign(q_neg_re_ff, q_prod_re_ff);
         rsp_imag_ff <= sat_sign(q_neg_im_ff, q_prod_im_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_real_part = rsp_real_ff;
   assign rsp_imag_part = rsp_imag_ff;

endmodule

/* hw/rtl/multi_bin_dft_accumulator.sv */
// Top level of the multi-bin running DFT accumulator.
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+----------------------
//  request  | req_cmd .. req_sample              | req_valid / req_ready
//  response | rsp_real_part, rsp_imag_part       | rsp_valid / rsp_ready
//  csr      | csr_index, csr_wdata               | csr_wen, no wait
//
// One request per cycle while req_ready is high; a read request returns its response after
// the queue hop, the phase multiply, the 18-stage CORDIC pipeline, the product and
// memory read-modify-write stages, the three-stage scale/saturate path and the output
// register. Accumulate requests give no response.
// After reset a clearing pass zeroes min(NUM_ELEMENTS, 1024) words; req_ready stays low.
// A stalled response freezes the back pipeline; the 4-entry queue takes requests until full.
module multi_bin_dft_accumulator import mbda_pkg::*; #(
   parameter int NUM_BINS     = 4,
   parameter int NUM_ELEMENTS = 1024,
   parameter int TABLE_BITS   = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wen,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic [ELEM_W-1:0]          req_element,
   input  logic [1:0]                 req_bin,
   input  logic [TIME_W-1:0]          req_step_time,
   input  logic                       req_first_of_step,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [OUT_W-1:0]    rsp_real_part,
   output logic signed [OUT_W-1:0]    rsp_imag_part
);

   cfg_type  cfg;
   item_type push_item, pop_item;
   logic     push, pop, q_not_empty, q_not_full, clear_busy;

   mbda_front #(.NUM_BINS(NUM_BINS), .NUM_ELEMENTS(NUM_ELEMENTS)) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_element       (req_element),
      .req_bin           (req_bin),
      .req_step_time     (req_step_time),
      .req_first_of_step (req_first_of_step),
      .req_sample        (req_sample),
      .q_not_full        (q_not_full),
      .clear_busy        (clear_busy),
      .push              (push),
      .push_item         (push_item),
      .cfg               (cfg)
   );

   mbda_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .not_empty (q_not_empty),
      .not_full  (q_not_full)
   );

   mbda_back #(
      .NUM_BINS     (NUM_BINS),
      .NUM_ELEMENTS (NUM_ELEMENTS),
      .TABLE_BITS   (TABLE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .q_item        (pop_item),
      .q_not_empty   (q_not_empty),
      .q_pop         (pop),
      .clear_busy    (clear_busy),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_real_part (rsp_real_part),
      .rsp_imag_part (rsp_imag_part)
   );

endmodule

/* tb/multi_bin_dft_accumulator_test.sv */
// Self-checking testbench for the multi-bin running DFT accumulator.
module multi_bin_dft_accumulator_test;
   import mbda_pkg::*;

   localparam int ELEMS        = 1024;
   localparam int BINS         = 4;
   localparam int PHASE_BITS   = 10;
   localparam int MAX_GAP      = 17;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 5000;
   localparam int PHASES       = 6;
   localparam int PER_PHASE    = 258;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 3'd6;

   class dft_scoreboard;
      logic [ACC_W-1:0] bin_re [BINS*ELEMS];
      logic [ACC_W-1:0] bin_im [BINS*ELEMS];
      logic [31:0]      last_time;
      logic [31:0]      interval;
      logic [31:0]      freq [4];
      logic [2:0]       lanes;
      logic [127:0]     pending_rsp [$];
      int               mismatches;
      int               checked;

      function new();
         foreach (bin_re[i]) begin
            bin_re[i] = '0;
            bin_im[i] = '0;
         end
         last_time  = '0;
         interval   = '0;
         foreach (freq[i]) freq[i] = '0;
         lanes      = 3'd4;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
         if (idx < CSR_FREQS_IN_USE) freq[idx] = v;
         else if (idx == CSR_FREQS_IN_USE) lanes = v[2:0];
      endfunction

      function longint q15_round(longint v);
         longint r;
         r = (v + 16384) >>> 15;
         if (r > 32767) r = 32767;
         if (r < -32767) r = -32767;
         return r;
      endfunction

      // CORDIC rotation on the truncated phase, folded into four quadrants
      function void rotate(logic [31:0] phase, output longint cs, output longint sn);
         logic [31:0] u;
         longint x, y, z, dx, dy, c0, s0;
         u = {phase[31 -: PHASE_BITS], {(32-PHASE_BITS){1'b0}}} + 32'h2000_0000;
         z = longint'(u[29:0]) - 64'sh2000_0000;
         x = 652032874;
         y = 0;
         for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
            end else begin
               x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
            end
         end
         c0 = q15_round(x);
         s0 = q15_round(y);
         case (u[31:30])
            2'd0: begin cs = c0;  sn = s0;  end
            2'd1: begin cs = -s0; sn = c0;  end
            2'd2: begin cs = -c0; sn = -s0; end
            default: begin cs = s0; sn = -c0; end
         endcase
      endfunction

      function logic [63:0] scaled(logic [ACC_W-1:0] a);
         longint      v;
         logic [63:0] m, mag, lim, prod;
         v    = longint'(signed'(a));
         m    = 64'(interval) << 1;
         mag  = (v < 0) ? 64'(-v) : 64'(v);
         lim  = (v < 0) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
         prod = (m != 0 && mag > lim / m) ? lim : mag * m;
         return (v < 0) ? -prod : prod;
      endfunction

      function void note_request(logic cmd, logic [9:0] elem, logic [1:0] bin,
                                 logic [31:0] t, logic first, logic signed [15:0] smp);
         int           use_n, k;
         longint       cs, sn, tr, ti;
         logic [127:0] exp_item;
         if (cmd == CMD_READ) begin
            k = bin * ELEMS + elem;
            exp_item = {scaled(bin_re[k]), scaled(bin_im[k])};
            pending_rsp.insert(pending_rsp.size(), exp_item);
            return;
         end
         if (first) begin
            interval  = t - last_time;
            last_time = t;
         end
         use_n = lanes;
         if (use_n < 1) use_n = 1;
         if (use_n > BINS) use_n = BINS;
         for (int b = 0; b < use_n; b++) begin
            k = b * ELEMS + elem;
            rotate(freq[b] * t, cs, sn);
            tr = (longint'(smp) * cs + 16384) >>> 15;
            ti = (longint'(smp) * (-sn) + 16384) >>> 15;
            bin_re[k] = bin_re[k] + tr[ACC_W-1:0];
            bin_im[k] = bin_im[k] + ti[ACC_W-1:0];
         end
      endfunction

      function void check_response(logic [63:0] re, logic [63:0] im);
         logic [127:0] exp_v;
         checked++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response re=%h im=%h", re, im);
            return;
         end
         exp_v = pending_rsp.pop_front();
         if (exp_v[127:64] !== re || exp_v[63:0] !== im) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d: expected re=%h im=%h, got re=%h im=%h",
                        checked, exp_v[127:64], exp_v[63:0], re, im);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]       csr_wdata = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_cmd = CMD_ACCUM;
   logic [9:0]        req_element = '0;
   logic [1:0]        req_bin = '0;
   logic [31:0]       req_step_time = '0;
   logic              req_first_of_step = 1'b0;
   logic signed [15:0] req_sample = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic signed [63:0] rsp_real_part, rsp_imag_part;

   dft_scoreboard sb = new();
   int  req_count = 0, rsp_count = 0, read_count = 0, csr_writes = 0;
   int  quiet_cycles = 0;
   int  tx_burst = 0;
   bit  hold_rsp = 1'b0;
   bit  no_gaps = 1'b0;
   logic [31:0] cur_time = '0;

   multi_bin_dft_accumulator u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // request/response monitor and stall watchdog
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         sb.note_request(req_cmd, req_element, req_bin, req_step_time,
                         req_first_of_step, req_sample);
         req_count++;
         if (req_cmd == CMD_READ) read_count++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_real_part, rsp_imag_part);
         rsp_count++;
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // response side: random back-pressure, bursts of steady ready, one long hold
   initial begin
      int gap, run, n0;
      run = 0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         if (run > 0) begin
            gap = 0;
            run--;
         end else begin
            gap = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 15) == 0) run = $urandom_range(10, 40);
         end
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         n0 = rsp_count;
         do @(negedge clock); while (rsp_count == n0);
      end
   end

   // called and returns at a falling edge; valid stays high for back-to-back requests
   task automatic send_request(logic cmd, logic [9:0] elem, logic [1:0] bin,
                               logic [31:0] t, logic first, logic signed [15:0] smp);
      int gap, n0;
      if (no_gaps || tx_burst > 0) begin
         gap = 0;
         if (tx_burst > 0) tx_burst--;
      end else begin
         gap = $urandom_range(0, MAX_GAP);
         if ($urandom_range(0, 15) == 0) tx_burst = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd           = cmd;
      req_element       = elem;
      req_bin           = bin;
      req_step_time     = t;
      req_first_of_step = first;
      req_sample        = smp;
      req_valid         = 1'b1;
      n0 = req_count;
      do @(negedge clock); while (req_count == n0);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      csr_wen   = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      sb.write_reg(idx, v);
      csr_writes++;
      @(negedge clock);
      csr_wen = 1'b0;
   endtask

   // wait until every read has answered and the pipeline has emptied
   task automatic drain();
      req_valid = 1'b0;
      while (sb.pending_rsp.size() != 0 || hold_rsp) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_freq();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h4000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [9:0] pick_element();
      return ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
   endfunction

   // mostly coherent steps: a step opener, then samples and reads; some noise mixed in
   task automatic random_request();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
         send_request(1'($urandom), 10'($urandom), 2'($urandom), $urandom,
                      1'($urandom), 16'($urandom));
      end else if (sel < 20) begin
         cur_time += ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 2000);
         send_request(CMD_ACCUM, pick_element(), 2'($urandom), cur_time, 1'b1,
                      16'($urandom));
      end else if (sel < 75) begin
         send_request(CMD_ACCUM, pick_element(), 2'($urandom), cur_time, 1'b0,
                      16'($urandom));
      end else begin
         send_request(CMD_READ, pick_element(), 2'($urandom), $urandom, 1'($urandom),
                      16'($urandom));
      end
   endtask

   initial begin
      logic [2:0] lane_set [PHASES] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3};
      repeat (11) @(negedge clock);
      reset = 1'b0;

      write_csr(CSR_FREQ_A, 32'h0);
      write_csr(CSR_FREQ_B, 32'hFFFF_FFFF);
      write_csr(CSR_FREQ_C, 32'h4000_0000);
      write_csr(CSR_FREQ_D, 32'h1234_5678);
      write_csr(CSR_FREQS_IN_USE, 32'd4);

      // directed: sample and time extremes, interval wrap, both commands, every bin
      send_request(CMD_ACCUM, 10'd0,    2'd0, 32'h0000_0000, 1'b1, 16'sh7FFF);
      send_request(CMD_ACCUM, 10'd1023, 2'd3, 32'h0000_0000, 1'b0, -16'sh8000);
      send_request(CMD_ACCUM, 10'd0,    2'd0, 32'hFFFF_FFFF, 1'b1, -16'sh8000);
      send_request(CMD_ACCUM, 10'd1023, 2'd1, 32'hFFFF_FFFF, 1'b0, 16'sh7FFF);
      send_request(CMD_ACCUM, 10'd5,    2'd2, 32'hFFFF_FFFF, 1'b0, 16'sh0000);
      for (int b = 0; b < BINS; b++) begin
         send_request(CMD_READ, 10'd0,    2'(b), 32'h0, 1'b0, 16'sh0);
         send_request(CMD_READ, 10'd1023, 2'(b), 32'hFFFF_FFFF, 1'b1, -16'sh1);
      end
      // interval wraps when time goes backwards; a read must not move it
      send_request(CMD_ACCUM, 10'd0,    2'd0, 32'h0000_0010, 1'b1, 16'sh4000);
      send_request(CMD_READ,  10'd0,    2'd0, 32'h8000_0000, 1'b1, 16'sh0);
      send_request(CMD_ACCUM, 10'd512,  2'd0, 32'h0000_0400, 1'b1, -16'sh0001);
      send_request(CMD_ACCUM, 10'd512,  2'd0, 32'h0000_0800, 1'b1, 16'sh0001);
      send_request(CMD_READ,  10'd512,  2'd0, 32'h0, 1'b0, 16'sh0);
      send_request(CMD_READ,  10'd512,  2'd3, 32'h0, 1'b0, 16'sh0);
      send_request(CMD_READ,  10'd0,    2'd1, 32'h0, 1'b0, 16'sh0);
      cur_time = 32'h0000_0800;

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_csr(CSR_FREQ_A, pick_freq());
         write_csr(CSR_FREQ_B, pick_freq());
         write_csr(CSR_FREQ_C, pick_freq());
         write_csr(CSR_FREQ_D, pick_freq());
         write_csr(CSR_FREQS_IN_USE, 32'(lane_set[p]));
         if (p == 1) write_csr(CSR_SPARE_IDX, $urandom);
         if (p == 3) begin
            // long response stall while requests keep coming: queue must fill up
            hold_rsp = 1'b1;
            no_gaps  = 1'b1;
            for (int i = 0; i < 80; i++)
               send_request((i % 3 == 0) ? CMD_ACCUM : CMD_READ, pick_element(),
                            2'($urandom), cur_time, 1'b0, 16'($urandom));
            no_gaps = 1'b0;
         end
         for (int i = 0; i < PER_PHASE; i++) random_request();
      end

      drain();
      $display("Covered %0d requests (%0d reads) over %0d register writes;", req_count,
               read_count, csr_writes);
      $display("%0d responses checked, %0d mismatches.", rsp_count, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
